// File: rtl/core/smi_pkg.sv
// Shared types, widths and register codes for the speed meter with injector pulse.
package smi_pkg;

  localparam int SPEED_BITS     = 24;
  localparam int PULSE_BITS     = 20;
  localparam int PRESCALE_BITS  = 8;
  localparam int LIMIT_BITS     = 16;
  localparam int BASE_BITS      = 12;
  localparam int OPCODE_BITS    = 2;
  localparam int OUT_FLAG_BITS  = 4;
  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  localparam int PERIOD_BITS_DEF = 16;
  localparam int SELECT_BITS_DEF = 3;

  localparam logic [PRESCALE_BITS-1:0] PRESCALE_RST  = 8'd5;
  localparam logic [LIMIT_BITS-1:0]    LIMIT_RST     = 16'd60000;
  localparam logic [BASE_BITS-1:0]     BASE_RST      = 12'd25;
  localparam logic [SPEED_BITS-1:0]    NUMERATOR_RST = 24'd3000000;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_TICK = 2'd0,
    OP_FALL = 2'd1,
    OP_RISE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_PRESCALE  = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_BASE      = 2'd2,
    REG_NUMERATOR = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/smi_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
module smi_div #(
  parameter int PERIOD_BITS = smi_pkg::PERIOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smi_pkg::SPEED_BITS-1:0] dividend,
  input  logic [PERIOD_BITS-1:0]        divisor,
  output smi_pkg::div_stat_t            stat,
  output logic [smi_pkg::SPEED_BITS-1:0] quotient
);
  import smi_pkg::*;

  localparam int CNT_BITS = $clog2(SPEED_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SPEED_BITS - 1);

  logic [PERIOD_BITS-1:0] rem;
  logic [PERIOD_BITS-1:0] rem_next;
  logic [SPEED_BITS-1:0]  quo;
  logic [PERIOD_BITS-1:0] dvsr;
  logic [CNT_BITS-1:0]    cnt;
  logic                   busy;
  logic                   done;
  logic [PERIOD_BITS:0]   trial;
  logic [PERIOD_BITS:0]   diff;
  logic                   fits;

  always_comb begin
    trial    = {rem, quo[SPEED_BITS-1]};
    diff     = trial - {1'b0, dvsr};
    fits     = trial >= {1'b0, dvsr};
    // The remainder stays below the divisor, so either choice fits its width.
    rem_next = fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SPEED_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider reports done while still iterating");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_busy_runs: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != CNT_LAST) && !start |=> busy && (cnt == $past(cnt) + 1'b1))
    else $error("divider stopped before its last step");

endmodule

// File: rtl/core/speed_meter_injector_pulse_core.sv
// Speed meter with period counter, injector one-shot and ADC start strobe.
//
// Every input beat gives one result beat. A base tick, a sensor falling edge, an
// unused opcode or a rising edge that sees a period count of zero goes from
// acceptance through the hold state to the output register. A rising edge with a
// nonzero period loads the bit-serial divider, which produces one quotient bit per
// cycle in 24 steps, then finishes and hands off. Only one beat is in
// work at a time; a new beat is accepted while the previous result still waits in
// the output register. Configuration writes over the APB port take effect at once.
module speed_meter_injector_pulse_core #(
  parameter int PERIOD_BITS = smi_pkg::PERIOD_BITS_DEF,
  parameter int SELECT_BITS = smi_pkg::SELECT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smi_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [smi_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [smi_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SELECT_BITS+7)/8)*8-1:0]   s_tdata,  // switch_code
  input  logic [smi_pkg::OPCODE_BITS-1:0]    s_tuser,  // opcode
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [smi_pkg::SPEED_BITS-1:0]     m_tdata,  // speed_value
  // speed_updated, period_zero_error, injector_on, adc_start
  output logic [smi_pkg::OUT_FLAG_BITS-1:0]  m_tuser
);
  import smi_pkg::*;

  localparam int PW       = ((PERIOD_BITS > LIMIT_BITS) ? PERIOD_BITS : LIMIT_BITS) + 1;
  localparam int DUR_BITS = BASE_BITS + (1 << SELECT_BITS) - 1;
  localparam int CMP_BITS = (DUR_BITS > PULSE_BITS) ? DUR_BITS : PULSE_BITS;
  localparam logic [PW-1:0] PERIOD_MAX =
    {{(PW - PERIOD_BITS){1'b0}}, {PERIOD_BITS{1'b1}}};
  localparam logic [PULSE_BITS-1:0] PULSE_MAX = {PULSE_BITS{1'b1}};

  // Configuration registers
  logic [PRESCALE_BITS-1:0] tick_prescale;
  logic [LIMIT_BITS-1:0]    period_limit;
  logic [BASE_BITS-1:0]     base_duration;
  logic [SPEED_BITS-1:0]    speed_numerator;

  // Block state
  logic [PRESCALE_BITS-1:0] prescale_count;
  logic [PERIOD_BITS-1:0]   period_count;
  logic [PULSE_BITS-1:0]    pulse_count;
  logic                     pulse_active;
  logic [SPEED_BITS-1:0]    last_speed;

  logic [PRESCALE_BITS-1:0] prescale_next;
  logic [PERIOD_BITS-1:0]   period_next;
  logic [PULSE_BITS-1:0]    pulse_next;
  logic                     active_next;
  logic                     upd_next;
  logic                     zero_next;
  logic                     adc_next;
  logic                     need_div;

  // Result waiting to move to the output register
  logic res_upd;
  logic res_zero;
  logic res_inj;
  logic res_adc;

  state_t state;
  state_t state_next;

  logic accept;
  logic out_free;
  logic load_out;
  logic div_start;

  logic [PRESCALE_BITS-1:0] pre_inc;
  logic                     tick_hit;
  logic [PW-1:0]            period_inc;
  logic [PW-1:0]            period_sat;
  logic [DUR_BITS-1:0]      duration;
  logic [SELECT_BITS-1:0]   code;
  logic                     cfg_write;
  reg_t                     cfg_sel;

  div_stat_t             div_stat;
  logic [SPEED_BITS-1:0] quotient;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_prescale   <= PRESCALE_RST;
      period_limit    <= LIMIT_RST;
      base_duration   <= BASE_RST;
      speed_numerator <= NUMERATOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_PRESCALE:  tick_prescale   <= pwdata[PRESCALE_BITS-1:0];
        REG_LIMIT:     period_limit    <= pwdata[LIMIT_BITS-1:0];
        REG_BASE:      base_duration   <= pwdata[BASE_BITS-1:0];
        REG_NUMERATOR: speed_numerator <= pwdata[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PRESCALE:  prdata = APB_DATA_BITS'(tick_prescale);
      REG_LIMIT:     prdata = APB_DATA_BITS'(period_limit);
      REG_BASE:      prdata = APB_DATA_BITS'(base_duration);
      REG_NUMERATOR: prdata = APB_DATA_BITS'(speed_numerator);
      default:       prdata = '0;
    endcase
  end

  // ---------------- per-beat update ----------------
  assign accept = s_tvalid && s_tready;
  assign code   = s_tdata[SELECT_BITS-1:0];

  always_comb begin
    pre_inc    = prescale_count + 1'b1;
    tick_hit   = pre_inc >= tick_prescale;
    period_inc = PW'(period_count) + 1'b1;
    period_sat = period_inc;
    if (period_sat > PW'(period_limit)) begin
      period_sat = PW'(period_limit);
    end
    if (period_sat > PERIOD_MAX) begin
      period_sat = PERIOD_MAX;
    end
    duration = DUR_BITS'(base_duration) << code;

    prescale_next = prescale_count;
    period_next   = period_count;
    pulse_next    = pulse_count;
    active_next   = pulse_active;
    upd_next      = 1'b0;
    zero_next     = 1'b0;
    adc_next      = 1'b0;

    unique case (op_t'(s_tuser))
      OP_TICK: begin
        prescale_next = tick_hit ? '0 : pre_inc;
        if (tick_hit) begin
          period_next = period_sat[PERIOD_BITS-1:0];
          if (pulse_active && (pulse_count != PULSE_MAX)) begin
            pulse_next = pulse_count + 1'b1;
          end
        end
      end
      OP_FALL: begin
        adc_next = 1'b1;
      end
      OP_RISE: begin
        upd_next    = 1'b1;
        zero_next   = (period_count == '0);
        period_next = '0;
        active_next = 1'b1;
      end
      default: ;
    endcase

    // The pulse ends once its count passes the selected duration.
    if (active_next && (CMP_BITS'(pulse_next) > CMP_BITS'(duration))) begin
      active_next = 1'b0;
      pulse_next  = '0;
    end

    need_div = upd_next && !zero_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      pulse_count    <= '0;
      pulse_active   <= 1'b0;
      last_speed     <= '0;
    end else begin
      if (accept) begin
        prescale_count <= prescale_next;
        period_count   <= period_next;
        pulse_count    <= pulse_next;
        pulse_active   <= active_next;
        if (zero_next) begin
          last_speed <= '0;
        end
      end else if ((state == ST_DIV) && div_stat.done) begin
        last_speed <= quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_upd  <= upd_next;
      res_zero <= zero_next;
      res_inj  <= active_next;
      res_adc  <= adc_next;
    end
  end

  smi_div #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_numerator),
    .divisor  (period_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // ---------------- sequencer ----------------
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_div ? ST_DIV : ST_HOLD;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    load_out  = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = s_tvalid && need_div;
      end
      ST_DIV: ;
      ST_HOLD: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= last_speed;
      m_tuser <= {res_adc, res_inj, res_zero, res_upd};
    end
  end

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata == '0))
    else $error("period zero beat without cleared speed");
  a_pulse_idle: assert property (@(posedge clk) disable iff (rst)
    (pulse_count != '0) |-> pulse_active)
    else $error("pulse counter runs without an active pulse");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after accepting a beat");

endmodule
